// ===== hdl/crc16fb_pkg.sv =====
// Shared types, codes and the CRC byte update for the CRC-16 frame builder.
package crc16fb_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int BURST_MAX = 5;

    // Input item kind (carried on s_tuser)
    localparam logic ACT_BEGIN   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Output byte roles (carried on m_tuser)
    localparam logic [2:0] ROLE_START   = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd2;
    localparam logic [2:0] ROLE_CRC_HI  = 3'd3;
    localparam logic [2:0] ROLE_CRC_LO  = 3'd4;
    localparam logic [2:0] ROLE_END     = 3'd5;

    // Register indexes on the configuration channel
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // Result bytes produced by one input item
    typedef struct packed {
        logic [2:0]                  count;
        logic [BURST_MAX-1:0][7:0]   data;
        logic [BURST_MAX-1:0][2:0]   role;
    } burst_t;

    // CRC-16/CCITT-FALSE update over one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16_frame_builder_unit.sv =====
// Top level of the CRC-16/CCITT-FALSE frame builder: input register, burst register, config.
// An accepted request goes through the input register and then the burst register.
// One request per cycle while each request yields one byte (mid-frame payload) and the
// receiver is ready; a k-byte request holds the output burst register until all k are taken.
// The input register takes the next request while the burst register is still draining.
// Reset (synchronous, active low) clears both registers and frame state and presets markers.
module crc16_frame_builder_unit
    import crc16fb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] frame_length, [15:8] payload_byte
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // [7:0] out_byte
    output logic [2:0]   m_tuser,   // [2:0] byte_role
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data
);

    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;

    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_length_reg;
    logic [7:0]  in_payload_reg;

    logic [2:0]  out_cnt_reg;
    logic [2:0]  out_idx_reg;
    burst_t      out_burst_reg;

    burst_t      burst;
    logic        load;
    logic        out_last;
    logic        out_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= 8'd170;
            end_marker_reg   <= 8'd85;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = (out_cnt_reg != 3'd0);
    assign out_last = (out_idx_reg == out_cnt_reg - 3'd1);
    assign out_take = m_tvalid && m_tready;
    assign load     = in_valid_reg && (!m_tvalid || (out_take && out_last));
    assign s_tready = !in_valid_reg || load;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg  <= s_tuser;
            in_length_reg  <= s_tdata[7:0];
            in_payload_reg <= s_tdata[15:8];
        end
    end

    crc16fb_encoder u_encoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .action       (in_action_reg),
        .frame_length (in_length_reg),
        .payload_byte (in_payload_reg),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .burst        (burst)
    );

    // burst register: advance one byte per accepted result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 3'd0;
            out_idx_reg <= 3'd0;
        end else if (load) begin
            out_cnt_reg <= burst.count;
            out_idx_reg <= 3'd0;
        end else if (out_take) begin
            if (out_last) begin
                out_cnt_reg <= 3'd0;
                out_idx_reg <= 3'd0;
            end else begin
                out_idx_reg <= out_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_burst_reg <= burst;
        end
    end

    assign m_tdata = out_burst_reg.data[out_idx_reg];
    assign m_tuser = out_burst_reg.role[out_idx_reg];
    assign m_tlast = out_last;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= 3'd5)
        else $error("burst count out of range");

    a_idx_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_idx_reg < out_cnt_reg))
        else $error("burst index beyond count");

    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && out_last && !load) |=> !m_tvalid)
        else $error("output still valid after last byte with nothing loaded");

    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |=> (in_valid_reg && $stable(in_length_reg)
            && $stable(in_payload_reg) && $stable(in_action_reg)))
        else $error("pending request lost while output stalled");

endmodule

// ===== hdl/crc16fb_encoder.sv =====
// Frame state and CRC tracking; forms the result bytes of one input item.
module crc16fb_encoder
    import crc16fb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  logic         action,
    input  logic [7:0]   frame_length,
    input  logic [7:0]   payload_byte,
    input  logic [7:0]   start_marker,
    input  logic [7:0]   end_marker,
    output burst_t       burst
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  left_reg, left_next;
    logic        open_reg, open_next;

    logic [15:0] crc_new;
    logic [7:0]  left_dec;

    assign crc_new  = (action == ACT_BEGIN) ? crc16_byte(CRC_INIT, frame_length)
                                            : crc16_byte(crc_reg, payload_byte);
    assign left_dec = left_reg - 8'd1;

    always_comb begin
        burst     = '0;
        crc_next  = crc_reg;
        left_next = left_reg;
        open_next = open_reg;
        if (action == ACT_BEGIN) begin
            burst.data[0] = start_marker;
            burst.role[0] = ROLE_START;
            burst.data[1] = frame_length;
            burst.role[1] = ROLE_LENGTH;
            if (frame_length == 8'd0) begin
                burst.count   = 3'd5;
                burst.data[2] = crc_new[15:8];
                burst.role[2] = ROLE_CRC_HI;
                burst.data[3] = crc_new[7:0];
                burst.role[3] = ROLE_CRC_LO;
                burst.data[4] = end_marker;
                burst.role[4] = ROLE_END;
                crc_next      = CRC_INIT;
                left_next     = 8'd0;
                open_next     = 1'b0;
            end else begin
                burst.count = 3'd2;
                crc_next    = crc_new;
                left_next   = frame_length;
                open_next   = 1'b1;
            end
        end else if (open_reg) begin
            burst.data[0] = payload_byte;
            burst.role[0] = ROLE_PAYLOAD;
            if (left_dec == 8'd0) begin
                // last payload byte: append the trailer and close
                burst.count   = 3'd4;
                burst.data[1] = crc_new[15:8];
                burst.role[1] = ROLE_CRC_HI;
                burst.data[2] = crc_new[7:0];
                burst.role[2] = ROLE_CRC_LO;
                burst.data[3] = end_marker;
                burst.role[3] = ROLE_END;
                crc_next      = CRC_INIT;
                left_next     = 8'd0;
                open_next     = 1'b0;
            end else begin
                burst.count = 3'd1;
                crc_next    = crc_new;
                left_next   = left_dec;
            end
        end
        // payload with no frame open: drop, count stays zero
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            left_reg <= 8'd0;
            open_reg <= 1'b0;
        end else if (load) begin
            crc_reg  <= crc_next;
            left_reg <= left_next;
            open_reg <= open_next;
        end
    end

endmodule

// ===== test/crc16_frame_builder_unit_test.sv =====
// Self-checking testbench for the CRC-16 frame builder: random and directed stream traffic.
`timescale 1ns / 1ps

module crc16_frame_builder_unit_test
    import crc16fb_pkg::*;
();

    typedef struct {
        logic       act;
        logic [7:0] len;
        logic [7:0] pay;
    } frame_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] role;
        logic       last;
    } frame_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] frame_length, [15:8] payload_byte
    logic        s_tuser = ACT_BEGIN;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] out_byte
    logic [2:0]  m_tuser;        // [2:0] byte_role
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_START_MARKER;
    logic [7:0]  cfg_data = '0;

    // Frame state mirrored from the block
    logic [15:0] mdl_crc = CRC_INIT;
    logic [7:0]  mdl_left = '0;
    logic        mdl_open = 1'b0;
    logic [7:0]  mdl_start = 8'd170;
    logic [7:0]  mdl_end = 8'd85;

    frame_req_t  req_q[$];
    frame_byte_t bytes_due[$];

    int   bad_count = 0;
    int   n_queued = 0;
    int   n_accepted = 0;
    int   tx_gap = 0;
    int   rx_wait = 0;
    int   hold_asked = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    bit   steady = 1'b0;
    bit   gen_open = 1'b0;
    logic req_taken = 1'b0;
    logic byte_taken = 1'b0;

    crc16_frame_builder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // CRC-16/CCITT-FALSE, one data byte shifted in MSB first
    function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Work out the bytes one accepted request puts on the output stream
    function automatic void frame_model_step(input logic act, input logic [7:0] len,
                                             input logic [7:0] pay);
        frame_byte_t burst[$];
        bit          close_now;
        close_now = 1'b0;
        if (act == ACT_BEGIN) begin
            mdl_crc = crc_ccitt_next(CRC_INIT, len);
            burst.insert(burst.size(), '{mdl_start, ROLE_START, 1'b0});
            burst.insert(burst.size(), '{len, ROLE_LENGTH, 1'b0});
            if (len == 8'd0) begin
                close_now = 1'b1;
            end else begin
                mdl_open = 1'b1;
                mdl_left = len;
            end
        end else if (mdl_open) begin
            mdl_crc = crc_ccitt_next(mdl_crc, pay);
            burst.insert(burst.size(), '{pay, ROLE_PAYLOAD, 1'b0});
            mdl_left = mdl_left - 8'd1;
            close_now = (mdl_left == 8'd0);
        end
        if (close_now) begin
            burst.insert(burst.size(), '{mdl_crc[15:8], ROLE_CRC_HI, 1'b0});
            burst.insert(burst.size(), '{mdl_crc[7:0], ROLE_CRC_LO, 1'b0});
            burst.insert(burst.size(), '{mdl_end, ROLE_END, 1'b0});
            mdl_open = 1'b0;
            mdl_left = '0;
            mdl_crc = CRC_INIT;
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[i]) begin
            bytes_due.insert(bytes_due.size(), burst[i]);
        end
    endfunction

    // Monitor: check results, predict from accepted requests, track register writes
    always @(posedge aclk) begin
        frame_byte_t want;
        req_taken <= aresetn && s_tvalid && s_tready;
        byte_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (bytes_due.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("unexpected byte %h role %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.role
                        || m_tlast !== want.last) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("mismatch: got %h/%0d/%b, wanted %h/%0d/%b",
                                     m_tdata, m_tuser, m_tlast,
                                     want.value, want.role, want.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_accepted++;
                frame_model_step(s_tuser, s_tdata[7:0], s_tdata[15:8]);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_MARKER: begin
                        mdl_start = cfg_data;
                    end
                    REG_END_MARKER: begin
                        mdl_end = cfg_data;
                    end
                endcase
            end
        end
    end

    // Sender: present the next pending request after a random gap
    always @(negedge aclk) begin
        frame_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !req_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                nxt = req_q.pop_front();
                s_tuser <= nxt.act;
                s_tdata <= {nxt.pay, nxt.len};
                s_tvalid <= 1'b1;
                tx_gap = steady ? 0 : $urandom_range(0, 5);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result, plus long hold-offs on demand
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (byte_taken) begin
                rx_wait = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_asked != hold_served) begin
                hold_served++;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void queue_req(input logic act, input logic [7:0] len,
                                      input logic [7:0] pay);
        req_q.insert(req_q.size(), '{act, len, pay});
        n_queued++;
    endfunction

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every request is in and every byte is out, then let the pipe settle
    task automatic wait_drained();
        do @(negedge aclk); while (n_accepted != n_queued || bytes_due.size() != 0);
        repeat (6) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Mostly whole frames with random content; some cut short, some stray payload
    task automatic random_frames(input int target);
        int made;
        int pick;
        int len;
        int cut;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_req(ACT_PAYLOAD, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
                if (gen_open) begin
                    made++;
                end
            end else begin
                if (pick < 14) begin
                    len = $urandom_range(13, 255);
                    cut = $urandom_range(0, 6);
                end else begin
                    len = $urandom_range(0, 12);
                    cut = (pick < 24) ? $urandom_range(0, len) : len;
                end
                queue_req(ACT_BEGIN, 8'(len), 8'($urandom_range(0, 255)));
                for (int i = 0; i < cut; i++) begin
                    queue_req(ACT_PAYLOAD, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                end
                gen_open = (cut < len);
                made += 1 + cut;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: stray payload, empty frame, one-byte frame, abandoned frames
        queue_req(ACT_PAYLOAD, 8'hFF, 8'hFF);
        queue_req(ACT_BEGIN, 8'h00, 8'hFF);
        queue_req(ACT_BEGIN, 8'h01, 8'h00);
        queue_req(ACT_PAYLOAD, 8'h00, 8'h00);
        queue_req(ACT_BEGIN, 8'hFF, 8'h00);
        queue_req(ACT_PAYLOAD, 8'hFF, 8'hFF);
        queue_req(ACT_BEGIN, 8'h02, 8'hFF);
        queue_req(ACT_PAYLOAD, 8'h00, 8'hA5);
        queue_req(ACT_PAYLOAD, 8'hFF, 8'h5A);
        queue_req(ACT_PAYLOAD, 8'h00, 8'h3C);
        queue_req(ACT_BEGIN, 8'h03, 8'h00);
        queue_req(ACT_PAYLOAD, 8'h00, 8'h80);
        queue_req(ACT_PAYLOAD, 8'hFF, 8'h01);
        queue_req(ACT_PAYLOAD, 8'h00, 8'hFE);
        queue_req(ACT_BEGIN, 8'h80, 8'h00);
        queue_req(ACT_BEGIN, 8'h7F, 8'hFF);
        queue_req(ACT_BEGIN, 8'h00, 8'h00);
        wait_drained();

        write_reg(REG_START_MARKER, 8'h00);
        write_reg(REG_END_MARKER, 8'hFF);
        @(posedge aclk);
        gen_open = 1'b0;
        random_frames(50);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering requests
        write_reg(REG_START_MARKER, 8'hFF);
        write_reg(REG_END_MARKER, 8'h00);
        @(posedge aclk);
        random_frames(50);
        hold_asked++;
        wait_drained();

        // Back-to-back full-length frame with no idling on either side
        write_reg(REG_START_MARKER, 8'($urandom_range(0, 255)));
        write_reg(REG_END_MARKER, 8'($urandom_range(0, 255)));
        @(posedge aclk);
        steady = 1'b1;
        queue_req(ACT_BEGIN, 8'hFF, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 255; i++) begin
            queue_req(ACT_PAYLOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        gen_open = 1'b0;
        random_frames(10);
        wait_drained();
        steady = 1'b0;

        write_reg(REG_START_MARKER, 8'($urandom_range(0, 255)));
        write_reg(REG_END_MARKER, 8'($urandom_range(0, 255)));
        @(posedge aclk);
        random_frames(30);
        wait_drained();

        if (bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
